// ===== design/mpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_pkg: shared types for the two-key max priority queue
// Request and result item layouts, the sort key and its ordering, and the
// command that is broadcast to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package mpq_pkg;

    // Field widths fixed by the item layout.
    localparam int REQ_BITS   = 2;
    localparam int TAG_W      = 16;
    localparam int ID_BITS    = 20;
    localparam int SCORE_BITS = 10;

    // Widest stored tag that the block supports.
    localparam int TAG_MAX_BITS = 32;

    // Request codes.
    localparam logic [REQ_BITS-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_POP    = 2'd2;

    // One request item.
    typedef struct packed {
        logic [REQ_BITS-1:0]   req_type;
        logic [TAG_W-1:0]      rec_tag;
        logic [ID_BITS-1:0]    rec_id;
        logic [SCORE_BITS-1:0] rec_score;
    } req_t;

    // One result item.
    typedef struct packed {
        logic                  is_empty;
        logic [TAG_W-1:0]      top_tag;
        logic [ID_BITS-1:0]    top_id;
        logic [SCORE_BITS-1:0] top_score;
        logic                  insert_dropped;
    } rsp_t;

    // Sort key held by each cell.
    typedef struct packed {
        logic [SCORE_BITS-1:0] score;
        logic [ID_BITS-1:0]    id;
    } key_t;

    // Command broadcast to all cells in the same cycle.
    typedef struct packed {
        logic ins;
        logic pop;
        key_t key;
    } cell_cmd_t;

    // True when key a ranks strictly before key b: larger score, then smaller id.
    function automatic logic ranks_before(input key_t a, input key_t b);
        logic result;
        if (a.score != b.score)
        begin
            result = (a.score > b.score);
        end
        else
        begin
            result = (a.id < b.id);
        end
        return result;
    endfunction

endpackage
`default_nettype wire

// ===== design/mpq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mpq_cell: one position of the sorted chain
// Holds one record. On an insert it keeps its record, takes the new one, or
// takes its left neighbor's record; on a pop it takes its right neighbor's.
// ----------------------------------------------------------------------------
module mpq_cell #(
    parameter int TAG_BITS = 16
) (
    input  wire                     clk,
    input  wire                     occupied,
    input  mpq_pkg::cell_cmd_t      cmd,
    input  wire  [TAG_BITS-1:0]     tag_new,
    input  wire                     left_go,
    input  mpq_pkg::key_t           left_key,
    input  wire  [TAG_BITS-1:0]     left_tag,
    input  mpq_pkg::key_t           right_key,
    input  wire  [TAG_BITS-1:0]     right_tag,
    output logic                    go,
    output mpq_pkg::key_t           key,
    output logic [TAG_BITS-1:0]     tag
);

    mpq_pkg::key_t         key_reg;
    mpq_pkg::key_t         key_next;
    logic [TAG_BITS-1:0]   tag_reg;
    logic [TAG_BITS-1:0]   tag_next;

    // An empty position always gives way to a new record.
    assign go = !occupied || mpq_pkg::ranks_before(cmd.key, key_reg);

    // Choose what this position holds after the command.
    always_comb
    begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (cmd.ins && go)
        begin
            if (left_go)
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
            else
            begin
                key_next = cmd.key;
                tag_next = tag_new;
            end
        end
        else if (cmd.pop)
        begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    // Record storage needs no reset.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

    assign key = key_reg;
    assign tag = tag_reg;

endmodule
`default_nettype wire

// ===== design/max_priority_queue_two_key_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// max_priority_queue_two_key_top: bounded max priority queue, two-key order
// Records sit fully sorted in a chain of cells with the top at cell zero.
// ----------------------------------------------------------------------------
// Each request item is taken in turn: the edge that accepts it registers
// the request and raises busy, then every cell of the chain settles in
// parallel from its own compare and its neighbors while busy is high, and
// no new item is accepted until busy falls. The result item
// appears on rsp with done high during the cycle after the chain update, and
// the receiver cannot stall it; sample it on that cycle. There is no clearing
// pass after reset: only the fill count and the control registers are cleared,
// and cells beyond the fill count are never shown.
// ----------------------------------------------------------------------------
module max_priority_queue_two_key_top #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 16
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    output logic             busy,
    input  mpq_pkg::req_t    req,
    output logic             done,
    output mpq_pkg::rsp_t    rsp
);

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    // Control and request registers.
    logic                  busy_reg;
    logic                  done_reg;
    logic                  drop_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    mpq_pkg::cell_cmd_t    cmd_reg;
    mpq_pkg::cell_cmd_t    cmd_next;
    logic [TAG_BITS-1:0]   tag_new_reg;
    logic                  drop_next;

    // Chain wiring.
    mpq_pkg::cell_cmd_t    cell_cmd;
    logic                  go_w  [CAPACITY];
    mpq_pkg::key_t         key_w [CAPACITY];
    logic [TAG_BITS-1:0]   tag_w [CAPACITY];

    logic                                accept;
    logic                                full;
    logic [mpq_pkg::TAG_MAX_BITS-1:0]    tag_in_wide;
    logic [mpq_pkg::TAG_MAX_BITS-1:0]    tag_out_wide;

    assign accept = start && !busy_reg;
    assign full   = (count_reg == CNT_BITS'(CAPACITY));

    // Stored tag keeps its low TAG_BITS bits.
    assign tag_in_wide = mpq_pkg::TAG_MAX_BITS'(req.rec_tag);

    // Decode the request against the current fill count.
    always_comb
    begin
        cmd_next.ins = 1'b0;
        cmd_next.pop = 1'b0;
        cmd_next.key.score = req.rec_score;
        cmd_next.key.id    = req.rec_id;
        drop_next = 1'b0;
        unique case (req.req_type)
            mpq_pkg::REQ_INSERT:
            begin
                cmd_next.ins = !full;
                drop_next    = full;
            end
            mpq_pkg::REQ_POP:
            begin
                cmd_next.pop = (count_reg != '0);
            end
            default:
            begin
                cmd_next.ins = 1'b0;
            end
        endcase
    end

    // The command reaches the cells only in the cycle after acceptance.
    always_comb
    begin
        cell_cmd     = cmd_reg;
        cell_cmd.ins = busy_reg && cmd_reg.ins;
        cell_cmd.pop = busy_reg && cmd_reg.pop;
    end

    // Fill count follows the command applied to the chain.
    always_comb
    begin
        count_next = count_reg;
        if (cell_cmd.ins)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (cell_cmd.pop)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            cmd_reg   <= '0;
        end
        else
        begin
            busy_reg  <= accept;
            done_reg  <= busy_reg;
            count_reg <= count_next;
            if (accept)
            begin
                cmd_reg <= cmd_next;
            end
        end
    end

    // Request payload held for the update cycle and the result cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tag_new_reg <= tag_in_wide[TAG_BITS-1:0];
            drop_reg    <= drop_next;
        end
    end

    // The sorted chain.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int LEFT  = (i == 0) ? 0 : i - 1;
        localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;
        logic occupied;
        logic left_go;

        assign occupied = (CNT_BITS'(i) < count_reg);
        assign left_go  = (i == 0) ? 1'b0 : go_w[LEFT];

        mpq_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .clk       (clk),
            .occupied  (occupied),
            .cmd       (cell_cmd),
            .tag_new   (tag_new_reg),
            .left_go   (left_go),
            .left_key  (key_w[LEFT]),
            .left_tag  (tag_w[LEFT]),
            .right_key (key_w[RIGHT]),
            .right_tag (tag_w[RIGHT]),
            .go        (go_w[i]),
            .key       (key_w[i]),
            .tag       (tag_w[i])
        );
    end

    // Result: cell zero, with the top fields forced to zero while the queue is empty.
    assign tag_out_wide = mpq_pkg::TAG_MAX_BITS'(tag_w[0]);

    always_comb
    begin
        rsp.is_empty       = (count_reg == '0);
        rsp.top_tag        = rsp.is_empty ? '0 : tag_out_wide[mpq_pkg::TAG_W-1:0];
        rsp.top_id         = rsp.is_empty ? '0 : key_w[0].id;
        rsp.top_score      = rsp.is_empty ? '0 : key_w[0].score;
        rsp.insert_dropped = drop_reg;
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// ===== sim/mpq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_checker: result checker for the two-key max priority queue
// Watches the request and result channels of the queue. It keeps its own
// sorted copy of the records, works out the expected top for each accepted
// request item and compares every result item with the oldest expectation.
// ----------------------------------------------------------------------------
module mpq_checker #(
    parameter int CAPACITY = 64
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    input  wire            busy,
    input  mpq_pkg::req_t  req,
    input  wire            done,
    input  mpq_pkg::rsp_t  rsp,
    output int             mismatches,
    output int             outstanding,
    output int             drops_seen,
    output int             empty_pops
);

    // One record as the queue holds it.
    typedef struct packed {
        logic [mpq_pkg::TAG_W-1:0]      tag;
        logic [mpq_pkg::SCORE_BITS-1:0] score;
        logic [mpq_pkg::ID_BITS-1:0]    id;
    } record_t;

    // Sorted records, best first, and the expected results in order.
    record_t        ranked [CAPACITY];
    int             fill;
    mpq_pkg::rsp_t  pending_tops [$];
    int             result_index;

    // Prints one line per mismatch (up to a cap) and counts every one.
    task automatic report_mismatch(input string what);
        if (mismatches < 40)
        begin
            $display("[%0t ns] mismatch on result %0d: %s", $time, result_index, what);
        end
        mismatches++;
    endtask

    // True when record a is served before record b.
    function automatic logic served_first(input record_t a, input record_t b);
        logic first;
        if (a.score != b.score)
        begin
            first = (a.score > b.score);
        end
        else
        begin
            first = (a.id < b.id);
        end
        return first;
    endfunction

    // Applies one request to the sorted records and returns the top it leaves.
    function automatic mpq_pkg::rsp_t serve_request(input mpq_pkg::req_t r);
        mpq_pkg::rsp_t top;
        record_t       incoming;
        int            pos;
        top = '0;
        if (r.req_type == mpq_pkg::REQ_INSERT)
        begin
            incoming.tag   = r.rec_tag;
            incoming.score = r.rec_score;
            incoming.id    = r.rec_id;
            if (fill >= CAPACITY)
            begin
                top.insert_dropped = 1'b1;
                drops_seen++;
            end
            else
            begin
                // Equal keys go behind the records already held.
                pos = 0;
                while (pos < fill && !served_first(incoming, ranked[pos]))
                begin
                    pos++;
                end
                for (int i = fill; i > pos; i--)
                begin
                    ranked[i] = ranked[i-1];
                end
                ranked[pos] = incoming;
                fill++;
            end
        end
        else if (r.req_type == mpq_pkg::REQ_POP)
        begin
            if (fill == 0)
            begin
                empty_pops++;
            end
            else
            begin
                for (int i = 0; i < fill - 1; i++)
                begin
                    ranked[i] = ranked[i+1];
                end
                fill--;
            end
        end
        // Peek and the unused code leave the records alone.
        if (fill == 0)
        begin
            top.is_empty = 1'b1;
        end
        else
        begin
            top.top_tag   = ranked[0].tag;
            top.top_id    = ranked[0].id;
            top.top_score = ranked[0].score;
        end
        return top;
    endfunction

    // Compare results first, then record the item accepted at this edge.
    always @(posedge clk or negedge rst_n)
    begin
        mpq_pkg::rsp_t want;
        if (!rst_n)
        begin
            fill         = 0;
            result_index = 0;
            mismatches   = 0;
            drops_seen   = 0;
            empty_pops   = 0;
            pending_tops.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_tops.size() == 0)
                begin
                    report_mismatch("result arrived with nothing expected");
                end
                else
                begin
                    want = pending_tops.pop_front();
                    if (rsp.is_empty !== want.is_empty)
                    begin
                        report_mismatch($sformatf("is_empty %b, expected %b",
                                                  rsp.is_empty, want.is_empty));
                    end
                    if (rsp.top_tag !== want.top_tag)
                    begin
                        report_mismatch($sformatf("top_tag %h, expected %h",
                                                  rsp.top_tag, want.top_tag));
                    end
                    if (rsp.top_id !== want.top_id)
                    begin
                        report_mismatch($sformatf("top_id %h, expected %h",
                                                  rsp.top_id, want.top_id));
                    end
                    if (rsp.top_score !== want.top_score)
                    begin
                        report_mismatch($sformatf("top_score %0d, expected %0d",
                                                  rsp.top_score, want.top_score));
                    end
                    if (rsp.insert_dropped !== want.insert_dropped)
                    begin
                        report_mismatch($sformatf("insert_dropped %b, expected %b",
                                                  rsp.insert_dropped, want.insert_dropped));
                    end
                end
                result_index++;
            end
            if (start && !busy)
            begin
                pending_tops.push_back(serve_request(req));
            end
            outstanding <= pending_tops.size();
        end
    end

endmodule

// ===== sim/max_priority_queue_two_key_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_priority_queue_two_key_top_test: testbench for the two-key priority queue
// Drives a short directed sequence of request items, then phases that fill,
// mix and drain the queue with random records, with random gaps between
// items. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module max_priority_queue_two_key_top_test;

    // Request codes the package leaves unnamed.
    localparam logic [mpq_pkg::REQ_BITS-1:0] REQ_PEEK  = 2'd1;
    localparam logic [mpq_pkg::REQ_BITS-1:0] REQ_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1430;

    typedef enum int {PHASE_FILL, PHASE_MIXED, PHASE_DRAIN} phase_t;

    logic           clk   = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    mpq_pkg::req_t  req   = '0;
    logic           busy;
    logic           done;
    mpq_pkg::rsp_t  rsp;

    int mismatches;
    int outstanding;
    int drops_seen;
    int empty_pops;
    int inserts_sent;
    int pops_sent;
    int peeks_sent;
    int spares_sent;

    max_priority_queue_two_key_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    mpq_checker #(
        .CAPACITY (64)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .drops_seen  (drops_seen),
        .empty_pops  (empty_pops)
    );

    // Clock with a 2 ns period.
    always #1 clk = ~clk;

    // Presents one item and returns at the edge that accepts it.
    task automatic issue(input mpq_pkg::req_t item);
        start <= 1'b1;
        req   <= item;
        case (item.req_type)
            mpq_pkg::REQ_INSERT: inserts_sent++;
            mpq_pkg::REQ_POP:    pops_sent++;
            REQ_PEEK:            peeks_sent++;
            default:             spares_sent++;
        endcase
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Builds one request item from explicit field values.
    function automatic mpq_pkg::req_t make_item(input logic [1:0] kind,
                                                input logic [15:0] tag,
                                                input logic [19:0] id,
                                                input logic [9:0] score);
        mpq_pkg::req_t r;
        r.req_type  = kind;
        r.rec_tag   = tag;
        r.rec_id    = id;
        r.rec_score = score;
        return r;
    endfunction

    // Random record fields, often clustered so that keys tie.
    function automatic mpq_pkg::req_t random_item(input logic [1:0] kind);
        int            pick;
        logic [9:0]    score;
        logic [19:0]   id;
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            score = 10'($urandom_range(2));
        end
        else if (pick < 40)
        begin
            score = 10'(1021 + $urandom_range(2));
        end
        else
        begin
            score = 10'($urandom_range(1023));
        end
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            id = 20'($urandom_range(3));
        end
        else if (pick < 45)
        begin
            id = 20'hFFFFF - 20'($urandom_range(1));
        end
        else
        begin
            id = 20'($urandom_range(20'hFFFFF));
        end
        return make_item(kind, 16'($urandom_range(16'hFFFF)), id, score);
    endfunction

    // Holds the sender back until every expected result has come.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        phase_t      phase;
        int          phase_left;
        int          roll;
        int          guard;
        logic [1:0]  kind;
        phase        = PHASE_DRAIN;
        phase_left   = 0;
        inserts_sent = 0;
        pops_sent    = 0;
        peeks_sent   = 0;
        spares_sent  = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests on an empty queue, with stray field values.
        issue(make_item(REQ_PEEK, 16'hFFFF, 20'hFFFFF, 10'd1023));
        issue(make_item(mpq_pkg::REQ_POP, 16'h5A5A, 20'h12345, 10'd7));
        issue(make_item(REQ_SPARE, 16'hFFFF, 20'hFFFFF, 10'd1023));
        // Lowest score; then the smaller id wins on the same score.
        issue(make_item(mpq_pkg::REQ_INSERT, 16'hFFFF, 20'hFFFFF, 10'd0));
        issue(make_item(mpq_pkg::REQ_INSERT, 16'h0000, 20'h00000, 10'd0));
        // Highest score; an exact key tie keeps the earlier record first.
        issue(make_item(mpq_pkg::REQ_INSERT, 16'h1234, 20'd5, 10'd1023));
        issue(make_item(mpq_pkg::REQ_INSERT, 16'hABCD, 20'd5, 10'd1023));
        issue(make_item(mpq_pkg::REQ_INSERT, 16'h0001, 20'd4, 10'd1023));
        issue(make_item(REQ_PEEK, 16'h0000, 20'h00000, 10'd0));
        issue(make_item(REQ_SPARE, 16'h8001, 20'h80001, 10'd513));
        // Pops walk down through the tie and the low scores.
        issue(make_item(mpq_pkg::REQ_POP, 16'h0000, 20'h00000, 10'd0));
        issue(make_item(mpq_pkg::REQ_POP, 16'hFFFF, 20'hFFFFF, 10'd1023));
        issue(make_item(mpq_pkg::REQ_POP, 16'h0000, 20'h00000, 10'd0));
        issue(make_item(mpq_pkg::REQ_INSERT, 16'h5555, 20'hFFFFF, 10'd1023));
        issue(make_item(mpq_pkg::REQ_INSERT, 16'hAAAA, 20'h00000, 10'd512));
        issue(make_item(mpq_pkg::REQ_POP, 16'h0000, 20'h00000, 10'd0));
        issue(make_item(mpq_pkg::REQ_POP, 16'h0000, 20'h00000, 10'd0));
        issue(make_item(mpq_pkg::REQ_POP, 16'h0000, 20'h00000, 10'd0));
        issue(make_item(mpq_pkg::REQ_POP, 16'h0000, 20'h00000, 10'd0));
        drain_results();

        // Phases that fill the queue past full, mix, and drain past empty.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                case (phase)
                    PHASE_FILL:  phase = PHASE_MIXED;
                    PHASE_MIXED: phase = PHASE_DRAIN;
                    default:     phase = PHASE_FILL;
                endcase
                phase_left = $urandom_range(80, 130);
            end
            phase_left--;
            roll = $urandom_range(99);
            case (phase)
                PHASE_FILL:
                begin
                    kind = (roll < 90) ? mpq_pkg::REQ_INSERT :
                           (roll < 96) ? mpq_pkg::REQ_POP :
                           (roll < 99) ? REQ_PEEK : REQ_SPARE;
                end
                PHASE_MIXED:
                begin
                    kind = (roll < 46) ? mpq_pkg::REQ_INSERT :
                           (roll < 86) ? mpq_pkg::REQ_POP :
                           (roll < 96) ? REQ_PEEK : REQ_SPARE;
                end
                default:
                begin
                    kind = (roll < 12) ? mpq_pkg::REQ_INSERT :
                           (roll < 90) ? mpq_pkg::REQ_POP :
                           (roll < 97) ? REQ_PEEK : REQ_SPARE;
                end
            endcase
            issue(random_item(kind));

            // Occasional full pause, random gaps, and a stretch with no gaps.
            if (n % 350 == 349)
            begin
                drain_results();
            end
            else if ((n < 600 || n >= 900) && $urandom_range(99) < 12)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end

        // Wait for the last results, then wait on for any stray results.
        start <= 1'b0;
        @(posedge clk);
        guard = 0;
        while (outstanding != 0 && guard < 200)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (6) @(posedge clk);

        $display("Covered %0d inserts (%0d refused when full), %0d pops (%0d on empty),",
                 inserts_sent, drops_seen, pops_sent, empty_pops);
        $display("%0d peeks and %0d unused codes; %0d mismatches, %0d results missing.",
                 peeks_sent, spares_sent, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #500000;
        $display("Run timed out waiting on the queue.");
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
design/mpq_pkg.sv
design/mpq_cell.sv
design/max_priority_queue_two_key_top.sv
sim/mpq_checker.sv
sim/max_priority_queue_two_key_top_test.sv
